FILE: hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	// Default sizing of the queue.
	localparam int unsigned SPQ_DEPTH         = 16;
	localparam int unsigned SPQ_PAYLOAD_WIDTH = 32;

	// Field widths of the item and result transfers.
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned PRIO_W     = 16;
	localparam int unsigned POS_W      = 4;
	localparam int unsigned PORT_PL_W  = 32;
	localparam int unsigned PORT_CNT_W = 5;
	localparam int unsigned STATUS_W   = 2;

	// Operation codes carried by the func field.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_PEEK   = 2'd2
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Action broadcast to every cell of the row.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [PRIO_W-1:0] prio;
		logic [POS_W-1:0]         position;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/spq_cell.sv
`default_nettype none

module spq_cell #(
	parameter int unsigned INDEX         = 0,
	parameter int unsigned DEPTH         = 16,
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic [$clog2(DEPTH+1)-1:0]          cnt,
	input  spq_pkg::cell_cmd_t                  cmd,
	input  logic [PAYLOAD_WIDTH-1:0]            new_payload,
	input  logic                                prev_ge,
	input  logic [PAYLOAD_WIDTH-1:0]            prev_payload,
	input  logic signed [spq_pkg::PRIO_W-1:0]   prev_prio,
	input  logic [PAYLOAD_WIDTH-1:0]            next_payload,
	input  logic signed [spq_pkg::PRIO_W-1:0]   next_prio,
	output logic                                ge,
	output logic [PAYLOAD_WIDTH-1:0]            payload_q,
	output logic signed [spq_pkg::PRIO_W-1:0]   prio_q
);
	import spq_pkg::*;

	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [CntW-1:0] Idx = CntW'(INDEX);

	logic                     occupied;
	logic                     at_or_after_pos;
	logic [PAYLOAD_WIDTH-1:0] payload_nxt;
	logic signed [PRIO_W-1:0] prio_nxt;

	// The cell holds a live entry when its place lies below the count.
	assign occupied = (Idx < cnt);

	// A live entry whose priority is at least the new one stays ahead of it.
	assign ge = occupied && (prio_q >= cmd.prio);

	// The cell takes part in closing the gap from the removed place onwards.
	assign at_or_after_pos = ({{POS_W{1'b0}}, Idx} >= {{CntW{1'b0}}, cmd.position});

	// Next contents: keep, take the new entry, or shift from a neighbour.
	always_comb begin
		payload_nxt = payload_q;
		prio_nxt    = prio_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (!ge) begin
					if (prev_ge) begin
						payload_nxt = new_payload;
						prio_nxt    = cmd.prio;
					end else begin
						payload_nxt = prev_payload;
						prio_nxt    = prev_prio;
					end
				end
			end
			CELL_REMOVE: begin
				if (at_or_after_pos) begin
					payload_nxt = next_payload;
					prio_nxt    = next_prio;
				end
			end
			default: begin
			end
		endcase
	end

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		payload_q <= payload_nxt;
		prio_q    <= prio_nxt;
	end

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue_top.sv
// Sorted priority queue: up to DEPTH entries, each a payload with a signed
// 16-bit priority, held in a row of cells in descending priority order with
// equal priorities kept in arrival order. Every accepted item (insert, remove
// at a position, or peek) gives exactly one result in the cycle after it,
// showing the head entry, a head valid flag, the count and a status code. The
// queue takes one item every cycle unless in_stall holds it: each cell
// compares its own priority with the new one and shifts from a neighbour
// when the item is accepted. The result register decouples the two sides;
// in_stall is raised only while a result is held and out_stall is high.
// An insert into a full queue and a remove beyond the stored entries leave the
// queue unchanged and are flagged in status.
`default_nettype none

module sorted_priority_queue_top #(
	parameter int unsigned DEPTH         = spq_pkg::SPQ_DEPTH,
	parameter int unsigned PAYLOAD_WIDTH = spq_pkg::SPQ_PAYLOAD_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [spq_pkg::FUNC_W-1:0]            func,
	input  logic [spq_pkg::PORT_PL_W-1:0]         payload,
	input  logic signed [spq_pkg::PRIO_W-1:0]     priority_req,
	input  logic [spq_pkg::POS_W-1:0]             position,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [spq_pkg::PORT_PL_W-1:0]         head_payload,
	output logic signed [spq_pkg::PRIO_W-1:0]     head_priority,
	output logic                                  head_valid,
	output logic [spq_pkg::PORT_CNT_W-1:0]        count,
	output logic [spq_pkg::STATUS_W-1:0]          status
);
	import spq_pkg::*;

	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [CntW-1:0] Full = CntW'(DEPTH);

	logic                     in_xfer;
	logic [CntW-1:0]          count_q;
	logic [CntW-1:0]          count_nxt;
	logic                     ins_ok;
	logic                     rem_ok;
	cell_op_t                 op_sel;
	status_t                  status_nxt;
	cell_cmd_t                cmd;
	logic [PAYLOAD_WIDTH-1:0] new_payload;
	logic [PAYLOAD_WIDTH+PORT_PL_W-1:0] payload_ext;

	logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
	logic signed [PRIO_W-1:0] cell_prio    [DEPTH];
	logic [DEPTH-1:0]         cell_ge;

	logic [PAYLOAD_WIDTH-1:0] head_pl_nxt;
	logic signed [PRIO_W-1:0] head_pr_nxt;
	logic [PAYLOAD_WIDTH+PORT_PL_W-1:0] head_pl_ext;
	logic [CntW+PORT_CNT_W-1:0] count_ext;

	logic                     out_valid_q;
	logic [PORT_PL_W-1:0]     head_payload_q;
	logic signed [PRIO_W-1:0] head_priority_q;
	logic                     head_valid_q;
	logic [PORT_CNT_W-1:0]    count_out_q;
	status_t                  status_q;

	// Input side is held only while a result waits and the sink is stalling.
	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// The incoming payload is stored at the configured width.
	assign payload_ext = {{PAYLOAD_WIDTH{1'b0}}, payload};
	assign new_payload = payload_ext[PAYLOAD_WIDTH-1:0];

	assign ins_ok = (count_q < Full);
	assign rem_ok = ({{CntW{1'b0}}, position} < {{POS_W{1'b0}}, count_q});

	// Operation decode and status.
	always_comb begin
		op_sel     = CELL_HOLD;
		status_nxt = ST_DONE;
		unique case (func_t'(func))
			FUNC_INSERT: begin
				if (ins_ok) begin
					op_sel = CELL_INSERT;
				end else begin
					status_nxt = ST_FULL;
				end
			end
			FUNC_REMOVE: begin
				if (rem_ok) begin
					op_sel = CELL_REMOVE;
				end else begin
					status_nxt = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.op       = in_xfer ? op_sel : CELL_HOLD;
	assign cmd.prio     = priority_req;
	assign cmd.position = position;

	// Count after the operation.
	always_comb begin
		case (cmd.op)
			CELL_INSERT: count_nxt = count_q + CntW'(1);
			CELL_REMOVE: count_nxt = count_q - CntW'(1);
			default:     count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Row of cells, each linked to both neighbours.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_ge;
		logic [PAYLOAD_WIDTH-1:0] prev_payload;
		logic signed [PRIO_W-1:0] prev_prio;
		logic [PAYLOAD_WIDTH-1:0] next_payload;
		logic signed [PRIO_W-1:0] next_prio;

		if (i == 0) begin : g_first
			assign prev_ge      = 1'b1;
			assign prev_payload = '0;
			assign prev_prio    = '0;
		end else begin : g_mid_prev
			assign prev_ge      = cell_ge[i-1];
			assign prev_payload = cell_payload[i-1];
			assign prev_prio    = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_payload = '0;
			assign next_prio    = '0;
		end else begin : g_mid_next
			assign next_payload = cell_payload[i+1];
			assign next_prio    = cell_prio[i+1];
		end

		spq_cell #(
			.INDEX         (i),
			.DEPTH         (DEPTH),
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
		) u_cell (
			.clk          (clk),
			.cnt          (count_q),
			.cmd          (cmd),
			.new_payload  (new_payload),
			.prev_ge      (prev_ge),
			.prev_payload (prev_payload),
			.prev_prio    (prev_prio),
			.next_payload (next_payload),
			.next_prio    (next_prio),
			.ge           (cell_ge[i]),
			.payload_q    (cell_payload[i]),
			.prio_q       (cell_prio[i])
		);
	end

	// Head entry after the operation, taken from the cells' inputs.
	always_comb begin
		head_pl_nxt = cell_payload[0];
		head_pr_nxt = cell_prio[0];
		case (cmd.op)
			CELL_INSERT: begin
				if (!cell_ge[0]) begin
					head_pl_nxt = new_payload;
					head_pr_nxt = priority_req;
				end
			end
			CELL_REMOVE: begin
				if (position == '0) begin
					head_pl_nxt = cell_payload[1];
					head_pr_nxt = cell_prio[1];
				end
			end
			default: begin
			end
		endcase
	end

	assign head_pl_ext = {{PORT_PL_W{1'b0}}, head_pl_nxt};
	assign count_ext   = {{PORT_CNT_W{1'b0}}, count_nxt};

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (count_nxt != '0) begin
				head_payload_q  <= head_pl_ext[PORT_PL_W-1:0];
				head_priority_q <= head_pr_nxt;
				head_valid_q    <= 1'b1;
			end else begin
				head_payload_q  <= '0;
				head_priority_q <= '0;
				head_valid_q    <= 1'b0;
			end
			count_out_q <= count_ext[PORT_CNT_W-1:0];
			status_q    <= status_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign head_payload  = head_payload_q;
	assign head_priority = head_priority_q;
	assign head_valid    = head_valid_q;
	assign count         = count_out_q;
	assign status        = status_q;

	// The count never runs past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Full)
		else $error("entry count exceeds queue depth");

	// The first two live entries stay in descending priority order.
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CntW'(2) |-> cell_prio[0] >= cell_prio[1])
		else $error("head entries out of priority order");

	// An insert into a full queue leaves the count alone and reports it.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && func == FUNC_INSERT && count_q == Full
		|=> count_q == Full && status_q == ST_FULL)
		else $error("full insert not dropped and flagged");

	// A valid remove takes exactly one entry away.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == CELL_REMOVE |=> count_q == $past(count_q) - CntW'(1))
		else $error("remove did not lower the count by one");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH   = SPQ_DEPTH;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int PHASE_LEN     = 40;
	localparam int SETTLE_CYCLES = 5;

	// The spare func code, which the queue must treat as a peek.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;
	localparam logic signed [PRIO_W-1:0] PRIO_MIN = 16'sh8000;

	// What one result transfer reports about the queue.
	typedef struct packed {
		logic [PORT_PL_W-1:0]     payload;
		logic signed [PRIO_W-1:0] prio;
		logic                     valid;
		logic [PORT_CNT_W-1:0]    len;
		status_t                  st;
	} head_report_t;

	// One directed item; the report is typed in only where fixed is set.
	typedef struct packed {
		logic [FUNC_W-1:0]        op;
		logic [PORT_PL_W-1:0]     pl;
		logic signed [PRIO_W-1:0] pr;
		logic [POS_W-1:0]         pos;
		logic                     fixed;
		head_report_t             want;
	} stim_row_t;

	localparam int NUM_DIRECTED = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = FUNC_PEEK;
	logic [PORT_PL_W-1:0] payload = '0;
	logic signed [PRIO_W-1:0] priority_req = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PORT_PL_W-1:0] head_payload;
	logic signed [PRIO_W-1:0] head_priority;
	logic head_valid;
	logic [PORT_CNT_W-1:0] count;
	logic [STATUS_W-1:0] status;

	// Shadow copy of the sorted entries, head at index 0.
	logic [PORT_PL_W-1:0] shadow_payload [QUEUE_DEPTH];
	logic signed [PRIO_W-1:0] shadow_prio [QUEUE_DEPTH];
	int shadow_len = 0;

	head_report_t expected_heads [$];
	int mismatches = 0;

	stim_row_t directed_rows [NUM_DIRECTED] = '{
		'{FUNC_PEEK,   32'h0, 16'sd0, 4'd0,  1'b1, '{32'h0, 16'sd0, 1'b0, 5'd0, ST_DONE}},
		'{FUNC_REMOVE, 32'h0, 16'sd0, 4'd0,  1'b1, '{32'h0, 16'sd0, 1'b0, 5'd0, ST_RANGE}},
		'{FUNC_REMOVE, 32'h0, 16'sd0, 4'd15, 1'b1, '{32'h0, 16'sd0, 1'b0, 5'd0, ST_RANGE}},
		'{FUNC_SPARE,  32'h0, 16'sd0, 4'd15, 1'b1, '{32'h0, 16'sd0, 1'b0, 5'd0, ST_DONE}},
		'{FUNC_INSERT, 32'hFFFF_FFFF, PRIO_MAX, 4'd0, 1'b1,
			'{32'hFFFF_FFFF, PRIO_MAX, 1'b1, 5'd1, ST_DONE}},
		'{FUNC_INSERT, 32'h0, PRIO_MIN, 4'd15, 1'b1,
			'{32'hFFFF_FFFF, PRIO_MAX, 1'b1, 5'd2, ST_DONE}},
		'{FUNC_INSERT, 32'h1, 16'sd0, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h2, 16'sd0, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h3, 16'sd100, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h4, -16'sd1, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h5, PRIO_MAX, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h6, PRIO_MIN, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h8000_0000, 16'sh4000, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h7FFF_FFFF, 16'shC000, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'hA5A5_A5A5, 16'sd1, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h5A5A_5A5A, -16'sd2, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h7, 16'sd100, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h8, 16'sd0, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'h9, 16'sh8001, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'hA, 16'sh7FFE, 4'd0, 1'b0, '0},
		'{FUNC_INSERT, 32'hB, 16'sd5, 4'd0, 1'b1,
			'{32'hFFFF_FFFF, PRIO_MAX, 1'b1, 5'd16, ST_FULL}},
		'{FUNC_REMOVE, 32'h0, 16'sd0, 4'd15, 1'b0, '0},
		'{FUNC_REMOVE, 32'h0, 16'sd0, 4'd15, 1'b1,
			'{32'hFFFF_FFFF, PRIO_MAX, 1'b1, 5'd15, ST_RANGE}},
		'{FUNC_REMOVE, 32'h0, 16'sd0, 4'd0, 1'b0, '0}
	};

	sorted_priority_queue_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.payload      (payload),
		.priority_req (priority_req),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.head_payload (head_payload),
		.head_priority(head_priority),
		.head_valid   (head_valid),
		.count        (count),
		.status       (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one accepted item to the shadow queue and returns the report it gives.
	function automatic head_report_t predict_head(input logic [FUNC_W-1:0] op,
			input logic [PORT_PL_W-1:0] pl, input logic signed [PRIO_W-1:0] pr,
			input logic [POS_W-1:0] pos);
		head_report_t rep;
		int slot;
		rep = '0;
		rep.st = ST_DONE;
		if (op == FUNC_INSERT) begin
			if (shadow_len >= QUEUE_DEPTH) begin
				rep.st = ST_FULL;
			end else begin
				// Equal priorities stay in arrival order, so skip past them.
				slot = 0;
				while (slot < shadow_len && shadow_prio[slot] >= pr)
					slot++;
				for (int k = shadow_len; k > slot; k--) begin
					shadow_payload[k] = shadow_payload[k-1];
					shadow_prio[k] = shadow_prio[k-1];
				end
				shadow_payload[slot] = pl;
				shadow_prio[slot] = pr;
				shadow_len++;
			end
		end else if (op == FUNC_REMOVE) begin
			if (int'(pos) >= shadow_len) begin
				rep.st = ST_RANGE;
			end else begin
				for (int k = int'(pos); k + 1 < shadow_len; k++) begin
					shadow_payload[k] = shadow_payload[k+1];
					shadow_prio[k] = shadow_prio[k+1];
				end
				shadow_len--;
			end
		end
		if (shadow_len > 0) begin
			rep.payload = shadow_payload[0];
			rep.prio = shadow_prio[0];
			rep.valid = 1'b1;
		end
		rep.len = PORT_CNT_W'(shadow_len);
		return rep;
	endfunction

	// Drives one item after an optional gap and waits for its transfer.
	task automatic send_item(input logic [FUNC_W-1:0] op, input logic [PORT_PL_W-1:0] pl,
			input logic signed [PRIO_W-1:0] pr, input logic [POS_W-1:0] pos,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		payload <= pl;
		priority_req <= pr;
		position <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Random stalls on the result side, with occasional long free-running stretches.
	initial begin : result_stall
		int run_len;
		int hold_len;
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 8);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			out_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			out_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
		end
	end

	// Every result transfer is checked against the oldest expected report.
	always @(posedge clk) begin
		head_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_heads.size() == 0) begin
				$error("result transfer with no report expected");
				mismatches++;
			end else begin
				want = expected_heads.pop_front();
				if (head_payload !== want.payload) begin
					$error("head_payload: expected %h, got %h", want.payload, head_payload);
					mismatches++;
				end
				if (head_priority !== want.prio) begin
					$error("head_priority: expected %0d, got %0d", want.prio, head_priority);
					mismatches++;
				end
				if (head_valid !== want.valid) begin
					$error("head_valid: expected %b, got %b", want.valid, head_valid);
					mismatches++;
				end
				if (count !== want.len) begin
					$error("count: expected %0d, got %0d", want.len, count);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		head_report_t rep;
		logic [FUNC_W-1:0] op;
		logic signed [PRIO_W-1:0] pr;
		logic [POS_W-1:0] pos;
		int phase;
		int steady;
		int pick;
		int ins_pct;
		int rem_pct;
		int gap;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty queue, extremes, ties, filling up and removals.
		for (int row = 0; row < NUM_DIRECTED; row++) begin
			send_item(directed_rows[row].op, directed_rows[row].pl, directed_rows[row].pr,
				directed_rows[row].pos, $urandom_range(0, 2));
			rep = predict_head(directed_rows[row].op, directed_rows[row].pl,
				directed_rows[row].pr, directed_rows[row].pos);
			expected_heads.push_back(directed_rows[row].fixed ? directed_rows[row].want : rep);
		end

		// Random phases that lean towards filling, draining or a balance of both.
		phase = 0;
		steady = 0;
		ins_pct = 45;
		rem_pct = 45;
		for (int item = 0; item < RANDOM_ITEMS; item++) begin
			if (item % PHASE_LEN == 0) begin
				phase = $urandom_range(0, 2);
				steady = ($urandom_range(0, 3) == 0);
				ins_pct = (phase == 0) ? 70 : (phase == 1) ? 20 : 45;
				rem_pct = (phase == 0) ? 20 : (phase == 1) ? 70 : 45;
			end
			pick = $urandom_range(0, 99);
			if (pick < ins_pct)
				op = FUNC_INSERT;
			else if (pick < ins_pct + rem_pct)
				op = FUNC_REMOVE;
			else
				op = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : FUNC_PEEK;

			// Many priorities come from a narrow band so that ties are common.
			pick = $urandom_range(0, 9);
			if (pick < 4)
				pr = PRIO_W'($urandom_range(0, 4)) - 16'sd2;
			else if (pick == 4)
				pr = $urandom_range(0, 1) ? PRIO_MAX : PRIO_MIN;
			else
				pr = PRIO_W'($urandom);

			// Removals mostly hit a stored entry; the rest pick any position, which may lie beyond the end.
			if (shadow_len > 0 && $urandom_range(0, 99) < 85)
				pos = POS_W'($urandom_range(0, shadow_len - 1));
			else
				pos = POS_W'($urandom_range(0, 15));

			pick = $urandom_range(0, 99);
			if (steady || pick < 60)
				gap = 0;
			else if (pick < 92)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 30);

			send_item(op, $urandom, pr, pos, gap);
			expected_heads.push_back(predict_head(op, payload, pr, pos));
		end
		in_valid <= 1'b0;

		while (expected_heads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[sorted_priority_queue_top] OK");
		else
			$display("[sorted_priority_queue_top] ERROR");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("[sorted_priority_queue_top] ERROR");
		$finish;
	end

endmodule
